// ===== design/mpsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsf_pkg
// shared types, codes and constants of the multi-protocol serial framer
// ----------------------------------------------------------------------------
package mpsf_pkg;

    localparam int NMEA_MAX_BYTES    = 512;
    localparam int UBX_PAYLOAD_BYTES = 92;
    localparam int BINARY_MAX_LEN    = 512;
    localparam int A5_MAX_LEN        = 64;

    localparam int POS_W = 10;

    localparam logic [2:0] PROTO_NMEA        = 3'd0;
    localparam logic [2:0] PROTO_WIND        = 3'd1;
    localparam logic [2:0] PROTO_UBX_PVT     = 3'd2;
    localparam logic [2:0] PROTO_STX_RADIO   = 3'd3;
    localparam logic [2:0] PROTO_A5_RADIO    = 3'd4;
    localparam logic [2:0] PROTO_BINARY      = 3'd5;
    localparam logic [2:0] PROTO_PASSTHROUGH = 3'd6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ABORTED  = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
    localparam logic [1:0] STATUS_FILTERED = 2'd3;

    localparam logic [0:0] REG_PASSTHROUGH_MODE   = 1'd0;
    localparam logic [0:0] REG_WIND_SENSOR_ENABLE = 1'd1;

    typedef struct packed {
        logic       passthrough_mode;
        logic       wind_sensor_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic       frame_end;
        logic [2:0] protocol;
        logic       has_data;
        logic [7:0] out_byte;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r1;
        res_t       r0;
    } parse_out_t;

    // wind sensor frame length by id character, zero for no id
    function automatic logic [3:0] wind_len(input logic [7:0] c);
        logic [3:0] len;
        case (c)
            8'h41:   len = 4'd10;
            8'h44:   len = 4'd15;
            8'h4d:   len = 4'd7;
            8'h53:   len = 4'd7;
            8'h57:   len = 4'd12;
            8'h61:   len = 4'd10;
            8'h64:   len = 4'd15;
            8'h77:   len = 4'd12;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== design/mpsf_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsf_parser
// byte-wise frame recognizer: parse state and up to two results per byte
// ----------------------------------------------------------------------------
module mpsf_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mpsf_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    input  wire logic [7:0]         in_byte,
    output mpsf_pkg::parse_out_t    out
);
    import mpsf_pkg::*;

    localparam logic [4:0] S_SYNC        = 5'd0;
    localparam logic [4:0] S_NMEA        = 5'd1;
    localparam logic [4:0] S_WIND        = 5'd2;
    localparam logic [4:0] S_UBX_PRE2    = 5'd3;
    localparam logic [4:0] S_UBX_CLASS   = 5'd4;
    localparam logic [4:0] S_UBX_ID      = 5'd5;
    localparam logic [4:0] S_UBX_LEN1    = 5'd6;
    localparam logic [4:0] S_UBX_LEN2    = 5'd7;
    localparam logic [4:0] S_UBX_PAYLOAD = 5'd8;
    localparam logic [4:0] S_UBX_CKA     = 5'd9;
    localparam logic [4:0] S_UBX_CKB     = 5'd10;
    localparam logic [4:0] S_STX_CMD     = 5'd11;
    localparam logic [4:0] S_STX_DATA    = 5'd12;
    localparam logic [4:0] S_A5_PROTID   = 5'd13;
    localparam logic [4:0] S_A5_LEN      = 5'd14;
    localparam logic [4:0] S_A5_DATA     = 5'd15;
    localparam logic [4:0] S_BIN_LEN1    = 5'd16;
    localparam logic [4:0] S_BIN_LEN2    = 5'd17;
    localparam logic [4:0] S_BIN_DATA    = 5'd18;

    logic [4:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] exp_len_reg, exp_len_next;
    logic [7:0]       len_low_reg, len_low_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       rx_ck_a_reg, rx_ck_a_next;
    logic [7:0]       sensor_id_reg, sensor_id_next;
    logic             dollar_reg, dollar_next;
    logic             open_reg, open_next;

    logic [2:0]       kind;
    logic [7:0]       c;
    logic [7:0]       sum_a_add;
    logic [7:0]       sum_b_add;
    logic [POS_W-1:0] pos_inc;
    logic [3:0]       wlen;
    logic             nmea_char;
    logic             is_term;
    logic [15:0]      bin_len;
    res_t             abort_res;

    always_comb begin
        case (state_reg)
            S_NMEA: kind = PROTO_NMEA;
            S_WIND: kind = PROTO_WIND;
            S_UBX_PRE2, S_UBX_CLASS, S_UBX_ID, S_UBX_LEN1, S_UBX_LEN2,
            S_UBX_PAYLOAD, S_UBX_CKA, S_UBX_CKB: kind = PROTO_UBX_PVT;
            S_STX_CMD, S_STX_DATA: kind = PROTO_STX_RADIO;
            S_A5_PROTID, S_A5_LEN, S_A5_DATA: kind = PROTO_A5_RADIO;
            default: kind = PROTO_BINARY;
        endcase
    end

    assign c         = in_byte;
    assign sum_a_add = sum_a_reg + c;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign wlen      = wind_len(c);
    assign is_term   = (c == 8'h0d) || (c == 8'h0a);
    assign nmea_char = ((c >= 8'h20) && (c <= 8'h7e)) || is_term;
    assign bin_len   = {c, len_low_reg};

    always_comb begin
        abort_res = '0;
        abort_res.protocol  = kind;
        abort_res.frame_end = 1'b1;
        abort_res.status    = STATUS_ABORTED;
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        exp_len_next   = exp_len_reg;
        len_low_next   = len_low_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        rx_ck_a_next   = rx_ck_a_reg;
        sensor_id_next = sensor_id_reg;
        dollar_next    = dollar_reg;
        open_next      = open_reg;
        out            = '0;

        if (cfg.passthrough_mode) begin
            out.r0.out_byte  = c;
            out.r0.has_data  = 1'b1;
            out.r0.protocol  = PROTO_PASSTHROUGH;
            out.r0.frame_end = 1'b1;
            out.r0.status    = STATUS_OK;
            out.count        = 2'd1;
            if (open_reg) begin
                out.r1    = out.r0;
                out.r0    = abort_res;
                out.count = 2'd2;
            end
            state_next = S_SYNC;
            pos_next   = '0;
            open_next  = 1'b0;
        end else begin
            // default: pass the byte through as part of the current frame
            out.r0.out_byte = c;
            out.r0.has_data = 1'b1;
            out.r0.protocol = kind;
            out.count       = 2'd1;
            case (state_reg)
                S_SYNC: begin
                    out.count = 2'd1;
                    open_next = 1'b1;
                    pos_next  = POS_W'(1);
                    if (c == 8'h24 || c == 8'h21) begin
                        dollar_next        = (c == 8'h24);
                        state_next         = S_NMEA;
                        out.r0.protocol    = PROTO_NMEA;
                    end else if (c == 8'hb5) begin
                        sum_a_next      = '0;
                        sum_b_next      = '0;
                        state_next      = S_UBX_PRE2;
                        pos_next        = '0;
                        out.r0.protocol = PROTO_UBX_PVT;
                    end else if (c == 8'h02) begin
                        state_next      = S_STX_CMD;
                        out.r0.protocol = PROTO_STX_RADIO;
                    end else if (c == 8'ha5) begin
                        state_next      = S_A5_PROTID;
                        out.r0.protocol = PROTO_A5_RADIO;
                    end else if (c == 8'h73) begin
                        state_next      = S_BIN_LEN1;
                        out.r0.protocol = PROTO_BINARY;
                    end else begin
                        out.count = 2'd0;
                        out.r0    = '0;
                        open_next = open_reg;
                        pos_next  = pos_reg;
                    end
                end
                S_NMEA: begin
                    if (!nmea_char) begin
                        out.r0 = abort_res;
                    end else if (pos_reg == POS_W'(1) && dollar_reg &&
                                 cfg.wind_sensor_enable && wlen != 4'd0) begin
                        exp_len_next    = POS_W'(wlen);
                        sensor_id_next  = c;
                        state_next      = S_WIND;
                        pos_next        = POS_W'(2);
                        out.r0.protocol = PROTO_WIND;
                    end else if (pos_reg >= POS_W'(NMEA_MAX_BYTES - 1)) begin
                        out.r0 = abort_res;
                    end else if (is_term) begin
                        out.r0.out_byte  = 8'h0d;
                        out.r1.out_byte  = 8'h0a;
                        out.r1.has_data  = 1'b1;
                        out.r1.protocol  = PROTO_NMEA;
                        out.r1.frame_end = 1'b1;
                        out.r1.status    = STATUS_OK;
                        out.count        = 2'd2;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                S_WIND: begin
                    pos_next = pos_inc;
                    if (pos_inc >= exp_len_reg) begin
                        out.r0.frame_end = 1'b1;
                        out.r0.status = (sensor_id_reg == 8'h53 || sensor_id_reg == 8'h57 ||
                                         sensor_id_reg == 8'h77) ? STATUS_OK
                                                                 : STATUS_FILTERED;
                    end
                end
                S_UBX_PRE2: begin
                    if (c != 8'h62) out.r0 = abort_res;
                    else state_next = S_UBX_CLASS;
                end
                S_UBX_CLASS: begin
                    if (c != 8'h01) begin
                        out.r0 = abort_res;
                    end else begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        state_next = S_UBX_ID;
                    end
                end
                S_UBX_ID: begin
                    if (c != 8'h07) begin
                        out.r0 = abort_res;
                    end else begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        state_next = S_UBX_LEN1;
                    end
                end
                S_UBX_LEN1: begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    state_next = S_UBX_LEN2;
                end
                S_UBX_LEN2: begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    pos_next   = '0;
                    state_next = S_UBX_PAYLOAD;
                end
                S_UBX_PAYLOAD: begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    pos_next   = pos_inc;
                    if (pos_inc >= POS_W'(UBX_PAYLOAD_BYTES)) state_next = S_UBX_CKA;
                end
                S_UBX_CKA: begin
                    rx_ck_a_next = c;
                    state_next   = S_UBX_CKB;
                end
                S_UBX_CKB: begin
                    out.r0.frame_end = 1'b1;
                    out.r0.status = (rx_ck_a_reg == sum_a_reg && c == sum_b_reg) ?
                                    STATUS_OK : STATUS_CHECKSUM;
                end
                S_STX_CMD: begin
                    if (c == 8'h55 || c == 8'h52 || c == 8'h41) begin
                        exp_len_next = (c == 8'h41) ? POS_W'(5) : POS_W'(12);
                        pos_next     = POS_W'(2);
                        state_next   = S_STX_DATA;
                    end else if (c == 8'h43 || c == 8'h4f || c == 8'h6f) begin
                        out.r0.frame_end = 1'b1;
                        out.r0.status    = STATUS_OK;
                    end else begin
                        out.r0 = abort_res;
                    end
                end
                S_STX_DATA: begin
                    pos_next = pos_inc;
                    if (pos_inc > exp_len_reg) out.r0.frame_end = 1'b1;
                end
                S_A5_PROTID: begin
                    if (c != 8'h14) begin
                        out.r0 = abort_res;
                    end else begin
                        pos_next   = POS_W'(2);
                        state_next = S_A5_LEN;
                    end
                end
                S_A5_LEN: begin
                    if (c >= 8'(A5_MAX_LEN)) begin
                        out.r0 = abort_res;
                    end else begin
                        exp_len_next = POS_W'(c);
                        pos_next     = POS_W'(3);
                        state_next   = S_A5_DATA;
                    end
                end
                S_A5_DATA: begin
                    pos_next = pos_inc;
                    if (pos_inc > exp_len_reg + POS_W'(5)) out.r0.frame_end = 1'b1;
                end
                S_BIN_LEN1: begin
                    len_low_next = c;
                    pos_next     = POS_W'(2);
                    state_next   = S_BIN_LEN2;
                end
                S_BIN_LEN2: begin
                    if (bin_len > 16'(BINARY_MAX_LEN)) begin
                        out.r0 = abort_res;
                    end else begin
                        exp_len_next = bin_len[POS_W-1:0];
                        pos_next     = POS_W'(3);
                        state_next   = S_BIN_DATA;
                    end
                end
                S_BIN_DATA: begin
                    pos_next = pos_inc;
                    if (pos_inc > exp_len_reg) out.r0.frame_end = 1'b1;
                end
                default: begin
                    out.count = 2'd0;
                    out.r0    = '0;
                    state_next = S_SYNC;
                    pos_next   = '0;
                    open_next  = 1'b0;
                end
            endcase
            // any frame end or abort returns to sync
            if (state_reg != S_SYNC && out.count != 2'd0 &&
                (out.r0.frame_end || out.r1.frame_end)) begin
                state_next = S_SYNC;
                pos_next   = '0;
                open_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SYNC;
            pos_reg       <= '0;
            exp_len_reg   <= '0;
            len_low_reg   <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            rx_ck_a_reg   <= '0;
            sensor_id_reg <= '0;
            dollar_reg    <= 1'b0;
            open_reg      <= 1'b0;
        end else if (in_valid) begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            exp_len_reg   <= exp_len_next;
            len_low_reg   <= len_low_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            rx_ck_a_reg   <= rx_ck_a_next;
            sensor_id_reg <= sensor_id_next;
            dollar_reg    <= dollar_next;
            open_reg      <= open_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/mpsf_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsf_out_fifo
// four-entry result queue, takes up to two results per cycle, drains one
// ----------------------------------------------------------------------------
module mpsf_out_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mpsf_pkg::parse_out_t push_data,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mpsf_pkg::res_t            out_data
);
    import mpsf_pkg::*;

    res_t       mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_n;
    logic       pop;

    assign push_n    = push ? push_data.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) mem_reg[wr_ptr_reg] <= push_data.r0;
        if (push_n == 2'd2) mem_reg[wr_ptr_reg + 2'd1] <= push_data.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/multi_protocol_serial_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_protocol_serial_framer
// Serial byte framer for NMEA, wind sensor, UBX NAV-PVT, STX, 0xA5 and 0x73
// frames. One received byte per s_ transaction; frame bytes leave on m_ with
// the frame kind in tuser and tlast on the last result of a frame or abort.
// Usage:
//   - cfg_wr_en writes cfg_wdata to register cfg_index (0 passthrough_mode,
//     1 wind_sensor_enable) at the clock edge; write only while idle.
//   - A byte is parsed in the cycle it is accepted; its results are
//     registered into a four-entry output queue and offered on m_ from
//     the head of that queue.
//   - Throughput is one byte per cycle while s_tready is high. An NMEA
//     terminator (CR LF) and an abort ahead of a passthrough byte give two
//     results, one per m_ transfer; the queue depth sets how far s_ runs ahead.
//   - s_tready is high while the queue has room for two results, so an
//     m_ stall lets up to four results collect before s_ stalls.
//   - Reset returns the parser to wait-for-sync, clears both registers
//     and empties the queue.
// ----------------------------------------------------------------------------
module multi_protocol_serial_framer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_index,
    input  wire logic [0:0] cfg_wdata,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [5:0]      m_tuser,   // [0] has_data, [3:1] protocol, [5:4] status
    output logic            m_tlast    // frame_end
);
    import mpsf_pkg::*;

    cfg_t       cfg_reg;
    logic       in_accept;
    parse_out_t parse_out;
    res_t       head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PASSTHROUGH_MODE:   cfg_reg.passthrough_mode   <= cfg_wdata[0];
                REG_WIND_SENSOR_ENABLE: cfg_reg.wind_sensor_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;

    mpsf_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (in_accept),
        .in_byte  (s_tdata),
        .out      (parse_out)
    );

    mpsf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (parse_out),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = {head.status, head.protocol, head.has_data};
    assign m_tlast = head.frame_end;

endmodule
`default_nettype wire

// ===== sim/framer_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// framer_tb_pkg
// byte codes and wind sensor tables shared by the framer testbench modules
// ----------------------------------------------------------------------------
package framer_tb_pkg;

    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TILDE      = 8'h7e;
    localparam logic [7:0] CH_DEL        = 8'h7f;

    localparam logic [7:0] UBX_PREAMBLE_A = 8'hb5;
    localparam logic [7:0] UBX_PREAMBLE_B = 8'h62;
    localparam logic [7:0] UBX_CLASS_NAV = 8'h01;
    localparam logic [7:0] UBX_ID_PVT    = 8'h07;

    localparam logic [7:0] STX_SYNC      = 8'h02;
    localparam logic [7:0] CMD_U         = 8'h55;
    localparam logic [7:0] CMD_R         = 8'h52;
    localparam logic [7:0] CMD_A         = 8'h41;
    localparam logic [7:0] CMD_C         = 8'h43;
    localparam logic [7:0] CMD_O         = 8'h4f;
    localparam logic [7:0] CMD_LOWER_O   = 8'h6f;
    localparam logic [7:0] CMD_BAD       = 8'h58;

    localparam logic [7:0] A5_SYNC       = 8'ha5;
    localparam logic [7:0] A5_PROT_ID    = 8'h14;
    localparam logic [7:0] BIN_SYNC      = 8'h73;

    localparam logic [7:0] ID_UPPER_S    = 8'h53;
    localparam logic [7:0] ID_UPPER_W    = 8'h57;
    localparam logic [7:0] ID_LOWER_W    = 8'h77;

    // ids A D M S W a d w, entry 0 in the lowest bits
    localparam logic [7:0][7:0] WIND_IDS = {
        8'h77, 8'h64, 8'h61, 8'h57, 8'h53, 8'h4d, 8'h44, 8'h41
    };
    localparam logic [7:0][3:0] WIND_LENS = {
        4'd12, 4'd15, 4'd10, 4'd12, 4'd7, 4'd7, 4'd15, 4'd10
    };

endpackage

// ===== sim/frame_stream_checker.sv =====
// ----------------------------------------------------------------------------
// frame_stream_checker
// Watches the byte and result streams of the serial framer, tracks the
// register writes, predicts the results of every accepted byte and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_stream_checker
    import mpsf_pkg::*;
    import framer_tb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_index,
    input  wire logic [0:0] cfg_wdata,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // [7:0] out_byte
    input  wire logic [5:0] m_tuser,   // [0] has_data, [3:1] protocol, [5:4] status
    input  wire logic       m_tlast,
    output int              fail_count,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        ST_HUNT, ST_NMEA, ST_WIND,
        ST_UBX_PRE2, ST_UBX_CLASS, ST_UBX_ID, ST_UBX_LEN1, ST_UBX_LEN2,
        ST_UBX_BODY, ST_UBX_CKA, ST_UBX_CKB,
        ST_STX_CMD, ST_STX_BODY,
        ST_A5_PROTID, ST_A5_LEN, ST_A5_BODY,
        ST_BIN_LEN1, ST_BIN_LEN2, ST_BIN_BODY
    } parse_state_t;

    parse_state_t state;
    logic [9:0]   pos;
    logic [9:0]   exp_len;
    logic [7:0]   len_low;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [7:0]   rx_ck_a;
    logic [7:0]   sensor;
    logic         dollar;
    logic         open;
    logic         cfg_pass;
    logic         cfg_wind;

    res_t expected_results[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [2:0] kind_of(parse_state_t s);
        logic [2:0] k;
        case (s)
            ST_NMEA: k = PROTO_NMEA;
            ST_WIND: k = PROTO_WIND;
            ST_UBX_PRE2, ST_UBX_CLASS, ST_UBX_ID, ST_UBX_LEN1, ST_UBX_LEN2,
            ST_UBX_BODY, ST_UBX_CKA, ST_UBX_CKB: k = PROTO_UBX_PVT;
            ST_STX_CMD, ST_STX_BODY: k = PROTO_STX_RADIO;
            ST_A5_PROTID, ST_A5_LEN, ST_A5_BODY: k = PROTO_A5_RADIO;
            default: k = PROTO_BINARY;
        endcase
        return k;
    endfunction

    function automatic string show(res_t r);
        return $sformatf("byte=%02h has=%0d proto=%0d end=%0d status=%0d",
                         r.out_byte, r.has_data, r.protocol, r.frame_end, r.status);
    endfunction

    task automatic emit(input logic [7:0] b, input logic has, input logic [2:0] proto,
                        input logic last, input logic [1:0] st);
        res_t r;
        r.out_byte  = b;
        r.has_data  = has;
        r.protocol  = proto;
        r.frame_end = last;
        r.status    = st;
        expected_results.push_back(r);
    endtask

    task automatic pass_byte(input logic [7:0] b, input logic [2:0] proto);
        emit(b, 1'b1, proto, 1'b0, STATUS_OK);
    endtask

    task automatic close_frame();
        state = ST_HUNT;
        pos   = '0;
        open  = 1'b0;
    endtask

    task automatic abort_frame();
        emit(8'h00, 1'b0, kind_of(state), 1'b1, STATUS_ABORTED);
        close_frame();
    endtask

    task automatic finish_frame(input logic [7:0] b, input logic [2:0] proto,
                                input logic [1:0] st);
        emit(b, 1'b1, proto, 1'b1, st);
        close_frame();
    endtask

    task automatic ubx_accumulate(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        logic [15:0] bin_len;
        logic        hit;
        hit = 1'b0;
        if (cfg_pass) begin
            if (open)
                abort_frame();
            close_frame();
            emit(c, 1'b1, PROTO_PASSTHROUGH, 1'b1, STATUS_OK);
        end else begin
            case (state)
                ST_HUNT: begin
                    if (c == CH_DOLLAR || c == CH_BANG) begin
                        dollar = (c == CH_DOLLAR);
                        state = ST_NMEA; pos = 10'd1; open = 1'b1;
                        pass_byte(c, PROTO_NMEA);
                    end else if (c == UBX_PREAMBLE_A) begin
                        sum_a = '0; sum_b = '0;
                        state = ST_UBX_PRE2; pos = '0; open = 1'b1;
                        pass_byte(c, PROTO_UBX_PVT);
                    end else if (c == STX_SYNC) begin
                        state = ST_STX_CMD; pos = 10'd1; open = 1'b1;
                        pass_byte(c, PROTO_STX_RADIO);
                    end else if (c == A5_SYNC) begin
                        state = ST_A5_PROTID; pos = 10'd1; open = 1'b1;
                        pass_byte(c, PROTO_A5_RADIO);
                    end else if (c == BIN_SYNC) begin
                        state = ST_BIN_LEN1; pos = 10'd1; open = 1'b1;
                        pass_byte(c, PROTO_BINARY);
                    end
                end
                ST_NMEA: begin
                    if (!((c >= CH_SPACE && c <= CH_TILDE) || c == CH_CR || c == CH_LF)) begin
                        abort_frame();
                    end else begin
                        if (pos == 10'd1 && dollar && cfg_wind) begin
                            for (int i = 0; i < 8; i++) begin
                                if (!hit && WIND_IDS[i] == c) begin
                                    hit = 1'b1;
                                    exp_len = {6'd0, WIND_LENS[i]};
                                    sensor = c;
                                    state = ST_WIND;
                                    pos = 10'd2;
                                    pass_byte(c, PROTO_WIND);
                                end
                            end
                        end
                        if (!hit) begin
                            if (pos >= NMEA_MAX_BYTES - 1) begin
                                abort_frame();
                            end else if (c == CH_CR || c == CH_LF) begin
                                pass_byte(CH_CR, PROTO_NMEA);
                                emit(CH_LF, 1'b1, PROTO_NMEA, 1'b1, STATUS_OK);
                                close_frame();
                            end else begin
                                pos = pos + 10'd1;
                                pass_byte(c, PROTO_NMEA);
                            end
                        end
                    end
                end
                ST_WIND: begin
                    pos = pos + 10'd1;
                    if (pos >= exp_len) begin
                        if (sensor == ID_UPPER_S || sensor == ID_UPPER_W
                            || sensor == ID_LOWER_W)
                            finish_frame(c, PROTO_WIND, STATUS_OK);
                        else
                            finish_frame(c, PROTO_WIND, STATUS_FILTERED);
                    end else begin
                        pass_byte(c, PROTO_WIND);
                    end
                end
                ST_UBX_PRE2: begin
                    if (c != UBX_PREAMBLE_B) begin
                        abort_frame();
                    end else begin
                        state = ST_UBX_CLASS;
                        pass_byte(c, PROTO_UBX_PVT);
                    end
                end
                ST_UBX_CLASS: begin
                    if (c != UBX_CLASS_NAV) begin
                        abort_frame();
                    end else begin
                        ubx_accumulate(c);
                        state = ST_UBX_ID;
                        pass_byte(c, PROTO_UBX_PVT);
                    end
                end
                ST_UBX_ID: begin
                    if (c != UBX_ID_PVT) begin
                        abort_frame();
                    end else begin
                        ubx_accumulate(c);
                        state = ST_UBX_LEN1;
                        pass_byte(c, PROTO_UBX_PVT);
                    end
                end
                ST_UBX_LEN1: begin
                    ubx_accumulate(c);
                    state = ST_UBX_LEN2;
                    pass_byte(c, PROTO_UBX_PVT);
                end
                ST_UBX_LEN2: begin
                    ubx_accumulate(c);
                    pos = '0;
                    state = ST_UBX_BODY;
                    pass_byte(c, PROTO_UBX_PVT);
                end
                ST_UBX_BODY: begin
                    ubx_accumulate(c);
                    pos = pos + 10'd1;
                    if (pos >= UBX_PAYLOAD_BYTES)
                        state = ST_UBX_CKA;
                    pass_byte(c, PROTO_UBX_PVT);
                end
                ST_UBX_CKA: begin
                    rx_ck_a = c;
                    state = ST_UBX_CKB;
                    pass_byte(c, PROTO_UBX_PVT);
                end
                ST_UBX_CKB: begin
                    if (rx_ck_a == sum_a && c == sum_b)
                        finish_frame(c, PROTO_UBX_PVT, STATUS_OK);
                    else
                        finish_frame(c, PROTO_UBX_PVT, STATUS_CHECKSUM);
                end
                ST_STX_CMD: begin
                    if (c == CMD_U || c == CMD_R || c == CMD_A) begin
                        exp_len = (c == CMD_A) ? 10'd5 : 10'd12;
                        pos = 10'd2;
                        state = ST_STX_BODY;
                        pass_byte(c, PROTO_STX_RADIO);
                    end else if (c == CMD_C || c == CMD_O || c == CMD_LOWER_O) begin
                        finish_frame(c, PROTO_STX_RADIO, STATUS_OK);
                    end else begin
                        abort_frame();
                    end
                end
                ST_STX_BODY: begin
                    pos = pos + 10'd1;
                    if (pos > exp_len)
                        finish_frame(c, PROTO_STX_RADIO, STATUS_OK);
                    else
                        pass_byte(c, PROTO_STX_RADIO);
                end
                ST_A5_PROTID: begin
                    if (c != A5_PROT_ID) begin
                        abort_frame();
                    end else begin
                        pos = 10'd2;
                        state = ST_A5_LEN;
                        pass_byte(c, PROTO_A5_RADIO);
                    end
                end
                ST_A5_LEN: begin
                    if (c >= A5_MAX_LEN) begin
                        abort_frame();
                    end else begin
                        exp_len = {2'd0, c};
                        pos = 10'd3;
                        state = ST_A5_BODY;
                        pass_byte(c, PROTO_A5_RADIO);
                    end
                end
                ST_A5_BODY: begin
                    pos = pos + 10'd1;
                    if (pos > exp_len + 10'd5)
                        finish_frame(c, PROTO_A5_RADIO, STATUS_OK);
                    else
                        pass_byte(c, PROTO_A5_RADIO);
                end
                ST_BIN_LEN1: begin
                    len_low = c;
                    pos = 10'd2;
                    state = ST_BIN_LEN2;
                    pass_byte(c, PROTO_BINARY);
                end
                ST_BIN_LEN2: begin
                    bin_len = {c, len_low};
                    if (bin_len > BINARY_MAX_LEN) begin
                        abort_frame();
                    end else begin
                        exp_len = bin_len[9:0];
                        pos = 10'd3;
                        state = ST_BIN_BODY;
                        pass_byte(c, PROTO_BINARY);
                    end
                end
                ST_BIN_BODY: begin
                    pos = pos + 10'd1;
                    if (pos > exp_len)
                        finish_frame(c, PROTO_BINARY, STATUS_OK);
                    else
                        pass_byte(c, PROTO_BINARY);
                end
                default: close_frame();
            endcase
        end
    endtask

    always @(posedge aclk) begin
        res_t seen;
        res_t want;
        if (!aresetn) begin
            expected_results.delete();
            close_frame();
            exp_len  = '0;
            len_low  = '0;
            sum_a    = '0;
            sum_b    = '0;
            rx_ck_a  = '0;
            sensor   = '0;
            dollar   = 1'b0;
            cfg_pass = 1'b0;
            cfg_wind = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.out_byte  = m_tdata;
                seen.has_data  = m_tuser[0];
                seen.protocol  = m_tuser[3:1];
                seen.status    = m_tuser[5:4];
                seen.frame_end = m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, actual %s", $time, show(seen));
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        $display("%0t: mismatch, expected %s actual %s",
                                 $time, show(want), show(seen));
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (cfg_wr_en) begin
                if (cfg_index == REG_PASSTHROUGH_MODE)
                    cfg_pass = cfg_wdata[0];
                else if (cfg_index == REG_WIND_SENSOR_ENABLE)
                    cfg_wind = cfg_wdata[0];
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the serial framer: short directed frames, then
// random well-formed, broken and noise traffic under several register
// settings, with random gaps on the input side and random stalls on the
// result side. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsf_pkg::*;
    import framer_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [0:0] cfg_wdata = '0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = '0;
    logic       m_tready  = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int cycles = 0;
    int bytes_sent = 0;
    bit quiet = 1'b0;

    always #10 aclk = ~aclk;

    multi_protocol_serial_framer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    frame_stream_checker frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side stalls
    initial begin
        int stall;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_printable(input int n);
        repeat (n) push_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
    endtask

    // wait until every predicted transaction has left, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_regs(input logic pt, input logic wind);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PASSTHROUGH_MODE;
        cfg_wdata <= pt;
        @(negedge aclk);
        cfg_index <= REG_WIND_SENSOR_ENABLE;
        cfg_wdata <= wind;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_nmea(input logic [7:0] lead, input int n, input logic [7:0] term);
        push_byte(lead);
        push_printable(n);
        push_byte(term);
    endtask

    task automatic send_wind(input int k);
        push_byte(CH_DOLLAR);
        push_byte(WIND_IDS[k]);
        push_random(int'(WIND_LENS[k]) - 2);
    endtask

    task automatic send_ubx(input bit corrupt);
        logic [7:0] b;
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        ck_a = '0;
        ck_b = '0;
        push_byte(UBX_PREAMBLE_A);
        push_byte(UBX_PREAMBLE_B);
        for (int i = 0; i < 4 + UBX_PAYLOAD_BYTES; i++) begin
            case (i)
                0:       b = UBX_CLASS_NAV;
                1:       b = UBX_ID_PVT;
                2:       b = 8'(UBX_PAYLOAD_BYTES);
                3:       b = 8'h00;
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b);
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
        end
        if (corrupt) begin
            if ($urandom_range(0, 1))
                ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
            else
                ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
        end
        push_byte(ck_a);
        push_byte(ck_b);
    endtask

    task automatic send_stx(input logic [7:0] cmd);
        push_byte(STX_SYNC);
        push_byte(cmd);
        if (cmd == CMD_U || cmd == CMD_R)
            push_random(11);
        else if (cmd == CMD_A)
            push_random(4);
    endtask

    task automatic send_a5(input logic [7:0] len);
        push_byte(A5_SYNC);
        push_byte(A5_PROT_ID);
        push_byte(len);
        push_random(int'(len) + 3);
    endtask

    // a length above the limit is rejected, so only the header is sent
    task automatic send_bin(input logic [15:0] len);
        push_byte(BIN_SYNC);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        if (len <= BINARY_MAX_LEN)
            push_random((len < 3) ? 1 : int'(len) - 2);
    endtask

    task automatic send_broken();
        int stage;
        case ($urandom_range(0, 3))
            0: begin
                stage = $urandom_range(0, 2);
                push_byte(UBX_PREAMBLE_A);
                if (stage > 0) push_byte(UBX_PREAMBLE_B);
                if (stage > 1) push_byte(UBX_CLASS_NAV);
                push_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                push_byte(A5_SYNC);
                if ($urandom_range(0, 1)) begin
                    push_byte(A5_PROT_ID);
                    push_byte(8'($urandom_range(A5_MAX_LEN, 255)));
                end else begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
            2: begin
                push_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_BANG);
                push_printable($urandom_range(0, 5));
                if ($urandom_range(0, 1))
                    push_byte(8'($urandom_range(CH_DEL, 8'hff)));
                else
                    push_byte(8'($urandom_range(0, CH_SPACE - 1)));
            end
            default: begin
                push_byte(BIN_SYNC);
                push_byte(8'($urandom_range(0, 255)));
                push_byte(8'($urandom_range(2, 255)));
            end
        endcase
    endtask

    task automatic random_traffic(input int budget);
        int start;
        logic [7:0] cmd;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            quiet = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                    send_nmea($urandom_range(0, 1) ? CH_DOLLAR : CH_BANG,
                              $urandom_range(0, 15),
                              $urandom_range(0, 1) ? CH_CR : CH_LF);
                4, 5, 6: send_wind($urandom_range(0, 7));
                7: send_ubx($urandom_range(0, 2) == 0);
                8, 9: begin
                    case ($urandom_range(0, 6))
                        0:       cmd = CMD_U;
                        1:       cmd = CMD_R;
                        2:       cmd = CMD_A;
                        3:       cmd = CMD_C;
                        4:       cmd = CMD_O;
                        5:       cmd = CMD_LOWER_O;
                        default: cmd = 8'($urandom_range(0, 255));
                    endcase
                    send_stx(cmd);
                end
                10, 11: send_a5(8'($urandom_range(0, 9) == 0 ? A5_MAX_LEN - 1
                                                             : $urandom_range(0, 12)));
                12, 13: send_bin(16'($urandom_range(0, 9) == 0 ? $urandom_range(13, 40)
                                                               : $urandom_range(0, 12)));
                14, 15, 16: send_broken();
                default: push_random($urandom_range(1, 3));
            endcase
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames and rejects, registers at reset values
        send_stx(CMD_C);
        send_stx(CMD_LOWER_O);
        send_stx(CMD_BAD);
        push_byte(CH_DOLLAR);
        push_byte(CH_CR);
        push_byte(CH_BANG);
        push_byte(CH_DEL);
        push_byte(UBX_PREAMBLE_A);
        push_byte(8'h63);
        push_byte(A5_SYNC);
        push_byte(8'h15);
        push_byte(A5_SYNC);
        push_byte(A5_PROT_ID);
        push_byte(8'(A5_MAX_LEN));
        push_byte(BIN_SYNC);
        push_byte(8'h01);
        push_byte(8'h02);
        send_bin(16'd0);
        push_byte(8'h00);
        push_byte(8'hff);

        // longest frames and length limits
        send_nmea(CH_BANG, NMEA_MAX_BYTES - 2, CH_CR);
        send_bin(16'hffff);
        send_a5(8'(A5_MAX_LEN - 1));
        send_ubx(1'b0);
        send_ubx(1'b1);
        random_traffic(60);

        write_regs(1'b0, 1'b1);
        for (int k = 0; k < 8; k++)
            send_wind(k);
        random_traffic(60);

        // passthrough entered with a radio frame still open
        push_byte(A5_SYNC);
        push_byte(A5_PROT_ID);
        push_byte(8'h05);
        write_regs(1'b1, 1'b1);
        push_random(40);

        write_regs(1'b0, 1'b0);
        push_byte(UBX_PREAMBLE_A);
        push_byte(UBX_PREAMBLE_B);
        push_byte(UBX_CLASS_NAV);
        write_regs(1'b1, 1'b0);
        push_random(20);

        write_regs(1'b0, 1'b1);
        random_traffic(60);
        write_regs(1'b0, 1'b0);
        random_traffic(50);

        settle();
        repeat (12) @(negedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
